>>> rtl/eir_pkg.sv
// ----------------------------------------------------------------------------
// eir_pkg
// Shared types and constants for the eight-register instruction executor:
// instruction field positions, opcode, command and fault codes, and the
// bundle that the execute unit hands to the control logic.
// ----------------------------------------------------------------------------
package eir_pkg;

    // Word memory size used when the top level is not told otherwise.
    localparam int MEM_WORDS_DEFAULT = 1024;

    // Datapath and register file geometry.
    localparam int XLEN     = 32;
    localparam int RF_DEPTH = 8;
    localparam int RIDX_W   = 3;
    localparam int USED_W   = 11;
    localparam int LADDR_W  = 10;

    // Instruction field positions.
    localparam int OP_LSB  = 22;
    localparam int OP_W    = 3;
    localparam int RA_LSB  = 19;
    localparam int RB_LSB  = 16;
    localparam int RD_LSB  = 0;
    localparam int OFF_W   = 16;

    // Opcodes of the instruction set.
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 3'd0,
        OP_NOR  = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } op_t;

    // Request kinds on the input channel.
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    // Fault codes reported with each result.
    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_PC   = 2'd1,
        FAULT_ADDR = 2'd2
    } fault_t;

    // Outcome of executing one instruction, before any memory access.
    typedef struct packed {
        logic [XLEN-1:0]   npc;
        logic              wr;
        logic [RIDX_W-1:0] widx;
        logic [XLEN-1:0]   wval;
        logic [XLEN-1:0]   ea;
        logic              ea_ok;
        logic              is_lw;
        logic              is_sw;
        logic              is_halt;
    } exec_t;

endpackage

>>> rtl/eir_ram.sv
// ----------------------------------------------------------------------------
// eir_ram
// Generic synchronous RAM with one write port and one read port. Read data
// is registered and holds its value while no read is requested.
// ----------------------------------------------------------------------------
module eir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/eir_exec.sv
// ----------------------------------------------------------------------------
// eir_exec
// Execute unit. Decodes one instruction and, from the program counter and
// the two source register values, works out the next program counter, the
// register write and the effective address of a memory access.
// ----------------------------------------------------------------------------
module eir_exec #(
    parameter int MEM_WORDS = eir_pkg::MEM_WORDS_DEFAULT
) (
    input  logic [eir_pkg::XLEN-1:0] instr,
    input  logic [eir_pkg::XLEN-1:0] pc,
    input  logic [eir_pkg::XLEN-1:0] va,
    input  logic [eir_pkg::XLEN-1:0] vb,
    output eir_pkg::exec_t           result
);
    import eir_pkg::*;

    op_t               op;
    logic [RIDX_W-1:0] ra;
    logic [RIDX_W-1:0] rb;
    logic [RIDX_W-1:0] rd;
    logic [XLEN-1:0]   off;
    logic [XLEN-1:0]   pc1;
    logic [XLEN-1:0]   ea;

    // Field extraction and the adders shared by several opcodes.
    always_comb
    begin
        op  = op_t'(instr[OP_LSB +: OP_W]);
        ra  = instr[RA_LSB +: RIDX_W];
        rb  = instr[RB_LSB +: RIDX_W];
        rd  = instr[RD_LSB +: RIDX_W];
        off = {{(XLEN-OFF_W){instr[OFF_W-1]}}, instr[OFF_W-1:0]};
        pc1 = pc + XLEN'(1);
        ea  = va + off;
    end

    // Opcode decode.
    always_comb
    begin
        result         = '0;
        result.npc     = pc1;
        result.ea      = ea;
        result.ea_ok   = !ea[XLEN-1] && (ea < XLEN'(MEM_WORDS));
        unique case (op)
            OP_ADD:
            begin
                result.wr   = 1'b1;
                result.widx = rd;
                result.wval = va + vb;
            end
            OP_NOR:
            begin
                result.wr   = 1'b1;
                result.widx = rd;
                result.wval = ~(va | vb);
            end
            OP_LW:
            begin
                result.is_lw = 1'b1;
            end
            OP_SW:
            begin
                result.is_sw = 1'b1;
            end
            OP_BEQ:
            begin
                if (va == vb)
                begin
                    result.npc = pc1 + off;
                end
            end
            OP_JALR:
            begin
                // With both fields naming one register the link write wins.
                result.npc  = (ra == rb) ? pc1 : va;
                result.wr   = 1'b1;
                result.widx = rb;
                result.wval = pc1;
            end
            OP_HALT:
            begin
                result.is_halt = 1'b1;
            end
            OP_NOOP:
            begin
                result.wr = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/eight_register_isa_executor_top.sv
// ----------------------------------------------------------------------------
// eight_register_isa_executor_top
// Word-addressed processor with eight registers and one unified memory,
// driven one request at a time: load a memory word or execute an
// instruction.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. A load request, a step after halt
// and a step whose program counter lies outside the loaded words complete in
// stage one, and a load may follow a load in every cycle while the output
// is not stalled. Add, nor, branch, jump-and-link, halt, no-op and store
// word are fetched from the word memory, then read the register file and
// complete. Load word reads its data in a further stage, since the one
// port of the word memory carries both the fetch and the data access. The
// register file is two copies of an eight-entry RAM so that both source
// registers are read in the same cycle; valid bits make unwritten registers
// read as zero. Results are held in an output register, so a new request
// is taken while an earlier result waits. The word memory has no reset:
// fetching or loading an unwritten word gives an undefined value.
// ----------------------------------------------------------------------------
module eight_register_isa_executor_top #(
    parameter int MEM_WORDS = eir_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [eir_pkg::LADDR_W-1:0]      load_address,
    input  logic signed [eir_pkg::XLEN-1:0]  load_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [eir_pkg::XLEN-1:0]  next_pc,
    output logic                             halted,
    output logic                             reg_write_valid,
    output logic [eir_pkg::RIDX_W-1:0]       reg_write_index,
    output logic signed [eir_pkg::XLEN-1:0]  reg_write_value,
    output logic [1:0]                       fault
);
    import eir_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    // Architectural state.
    logic [XLEN-1:0]     pc_reg, pc_next;
    logic                halt_reg, halt_next;
    logic [USED_W-1:0]   used_words_reg, used_words_next;
    logic [RF_DEPTH-1:0] rf_valid_reg, rf_valid_next;

    // Stage one: fetch in flight, or a request that completes at once.
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_fetch_reg, s1_fetch_next;
    fault_t              s1_fault_reg, s1_fault_next;

    // Stage two: register read done, instruction executes.
    logic                s2_valid_reg, s2_valid_next;
    logic [XLEN-1:0]     s2_instr_reg, s2_instr_next;
    logic                s2_ra_ok_reg, s2_ra_ok_next;
    logic                s2_rb_ok_reg, s2_rb_ok_next;

    // Stage three: load word data returns.
    logic                s3_valid_reg, s3_valid_next;
    logic [RIDX_W-1:0]   s3_rb_reg, s3_rb_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [XLEN-1:0]     out_pc_reg, out_pc_next;
    logic                out_halt_reg, out_halt_next;
    logic                out_wvalid_reg, out_wvalid_next;
    logic [RIDX_W-1:0]   out_widx_reg, out_widx_next;
    logic [XLEN-1:0]     out_wval_reg, out_wval_next;
    fault_t              out_fault_reg, out_fault_next;

    // Memory ports.
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [XLEN-1:0]     mem_wdata, mem_rdata;
    logic                rf_we, rf_re;
    logic [RIDX_W-1:0]   rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [XLEN-1:0]     rf_wdata, rf_rdata_a, rf_rdata_b;

    // Control.
    exec_t               ex;
    logic [XLEN-1:0]     va, vb, pc_fwd;
    logic                halt_fwd;
    logic                out_free, s1_imm_done, s1_to_s2;
    logic                s2_lw_go, s2_mem, s2_done, s3_done;
    logic                can_accept, accept, is_step, load_ok, fetch_ok, do_fetch;

    // Unified word memory: instructions and data.
    eir_ram #(
        .WIDTH (XLEN),
        .DEPTH (MEM_WORDS)
    ) u_word_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Register file copy for the first source register.
    eir_ram #(
        .WIDTH (XLEN),
        .DEPTH (RF_DEPTH)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (rf_re),
        .raddr (rf_raddr_a),
        .rdata (rf_rdata_a)
    );

    // Register file copy for the second source register.
    eir_ram #(
        .WIDTH (XLEN),
        .DEPTH (RF_DEPTH)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (rf_re),
        .raddr (rf_raddr_b),
        .rdata (rf_rdata_b)
    );

    // Source values: unwritten registers and register zero read as zero.
    assign va = s2_ra_ok_reg ? rf_rdata_a : '0;
    assign vb = s2_rb_ok_reg ? rf_rdata_b : '0;

    eir_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .instr  (s2_instr_reg),
        .pc     (pc_reg),
        .va     (va),
        .vb     (vb),
        .result (ex)
    );

    // Completion and forwarding of the program counter and halt flag.
    always_comb
    begin
        out_free    = !out_valid_reg || !out_stall;
        s1_imm_done = s1_valid_reg && !s1_fetch_reg && out_free;
        s1_to_s2    = s1_valid_reg && s1_fetch_reg;
        s2_lw_go    = s2_valid_reg && ex.is_lw && ex.ea_ok;
        s2_mem      = s2_valid_reg && (ex.is_lw || ex.is_sw) && ex.ea_ok;
        s2_done     = s2_valid_reg && !s2_lw_go && out_free;
        s3_done     = s3_valid_reg && out_free;

        if (s2_done)
        begin
            pc_fwd = ex.npc;
        end
        else if (s3_done)
        begin
            pc_fwd = pc_reg + XLEN'(1);
        end
        else
        begin
            pc_fwd = pc_reg;
        end
        halt_fwd = halt_reg || (s2_done && ex.is_halt);
    end

    // Request acceptance and routing.
    always_comb
    begin
        can_accept = (!s1_valid_reg || s1_imm_done)
                     && (!s2_valid_reg || (s2_done && !s2_mem))
                     && (!s3_valid_reg || s3_done);
        accept   = in_valid && can_accept;
        is_step  = (command == CMD_STEP);
        load_ok  = XLEN'(load_address) < XLEN'(MEM_WORDS);
        fetch_ok = pc_fwd < XLEN'(used_words_reg);
        do_fetch = accept && is_step && !halt_fwd && fetch_ok;
    end

    assign in_stall = !can_accept;

    // Word memory port control: a data access owns the port, otherwise a
    // load request may write.
    always_comb
    begin
        if (s2_mem)
        begin
            mem_we    = s2_done && ex.is_sw && ex.ea_ok;
            mem_waddr = AW'(ex.ea);
            mem_wdata = vb;
        end
        else
        begin
            mem_we    = accept && !is_step && load_ok;
            mem_waddr = AW'(load_address);
            mem_wdata = $unsigned(load_data);
        end
        mem_re    = do_fetch || s2_lw_go;
        mem_raddr = s2_lw_go ? AW'(ex.ea) : AW'(pc_fwd);
    end

    // Register file port control.
    always_comb
    begin
        rf_re      = s1_to_s2;
        rf_raddr_a = mem_rdata[RA_LSB +: RIDX_W];
        rf_raddr_b = mem_rdata[RB_LSB +: RIDX_W];
        if (s3_valid_reg)
        begin
            rf_we    = s3_done && (s3_rb_reg != '0);
            rf_waddr = s3_rb_reg;
            rf_wdata = mem_rdata;
        end
        else
        begin
            rf_we    = s2_done && ex.wr && (ex.widx != '0);
            rf_waddr = ex.widx;
            rf_wdata = ex.wval;
        end
    end

    // Next state of the architectural registers and pipeline stages.
    always_comb
    begin
        pc_next         = pc_fwd;
        halt_next       = halt_fwd;
        used_words_next = used_words_reg;
        if (accept && !is_step && load_ok
            && (used_words_reg <= USED_W'(load_address)))
        begin
            used_words_next = USED_W'(load_address) + USED_W'(1);
        end
        rf_valid_next = rf_valid_reg;
        if (rf_we)
        begin
            rf_valid_next[rf_waddr] = 1'b1;
        end

        s1_valid_next = s1_valid_reg;
        s1_fetch_next = s1_fetch_reg;
        s1_fault_next = s1_fault_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_fetch_next = do_fetch;
            if (!is_step)
            begin
                s1_fault_next = load_ok ? FAULT_NONE : FAULT_ADDR;
            end
            else if (!halt_fwd && !fetch_ok)
            begin
                s1_fault_next = FAULT_PC;
            end
            else
            begin
                s1_fault_next = FAULT_NONE;
            end
        end
        else if (s1_imm_done || s1_to_s2)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        s2_instr_next = s2_instr_reg;
        s2_ra_ok_next = s2_ra_ok_reg;
        s2_rb_ok_next = s2_rb_ok_reg;
        if (s1_to_s2)
        begin
            s2_valid_next = 1'b1;
            s2_instr_next = mem_rdata;
            s2_ra_ok_next = rf_valid_reg[rf_raddr_a];
            s2_rb_ok_next = rf_valid_reg[rf_raddr_b];
        end
        else if (s2_done || s2_lw_go)
        begin
            s2_valid_next = 1'b0;
        end

        s3_valid_next = s3_valid_reg;
        s3_rb_next    = s3_rb_reg;
        if (s2_lw_go)
        begin
            s3_valid_next = 1'b1;
            s3_rb_next    = s2_instr_reg[RB_LSB +: RIDX_W];
        end
        else if (s3_done)
        begin
            s3_valid_next = 1'b0;
        end
    end

    // Output register: loaded by whichever stage completes.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_pc_next     = out_pc_reg;
        out_halt_next   = out_halt_reg;
        out_wvalid_next = out_wvalid_reg;
        out_widx_next   = out_widx_reg;
        out_wval_next   = out_wval_reg;
        out_fault_next  = out_fault_reg;
        if (s2_done || s3_done)
        begin
            out_valid_next  = 1'b1;
            out_pc_next     = pc_fwd;
            out_halt_next   = halt_fwd;
            out_wvalid_next = rf_we;
            out_widx_next   = rf_we ? rf_waddr : '0;
            out_wval_next   = rf_we ? rf_wdata : '0;
            out_fault_next  = (s2_done && (ex.is_lw || ex.is_sw) && !ex.ea_ok)
                              ? FAULT_ADDR : FAULT_NONE;
        end
        else if (s1_imm_done)
        begin
            out_valid_next  = 1'b1;
            out_pc_next     = pc_reg;
            out_halt_next   = halt_reg;
            out_wvalid_next = 1'b0;
            out_widx_next   = '0;
            out_wval_next   = '0;
            out_fault_next  = s1_fault_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            used_words_reg <= '0;
            rf_valid_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            used_words_reg <= used_words_next;
            rf_valid_reg   <= rf_valid_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_fetch_reg   <= s1_fetch_next;
        s1_fault_reg   <= s1_fault_next;
        s2_instr_reg   <= s2_instr_next;
        s2_ra_ok_reg   <= s2_ra_ok_next;
        s2_rb_ok_reg   <= s2_rb_ok_next;
        s3_rb_reg      <= s3_rb_next;
        out_pc_reg     <= out_pc_next;
        out_halt_reg   <= out_halt_next;
        out_wvalid_reg <= out_wvalid_next;
        out_widx_reg   <= out_widx_next;
        out_wval_reg   <= out_wval_next;
        out_fault_reg  <= out_fault_next;
    end

    assign out_valid       = out_valid_reg;
    assign next_pc         = $signed(out_pc_reg);
    assign halted          = out_halt_reg;
    assign reg_write_valid = out_wvalid_reg;
    assign reg_write_index = out_widx_reg;
    assign reg_write_value = $signed(out_wval_reg);
    assign fault           = out_fault_reg;

    // At most one request is inside the execution stages at any time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_valid_reg, s2_valid_reg, s3_valid_reg}))
        else $error("more than one request in the execution stages");

    // The single word memory port is never asked to read and write at once.
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("word memory read and write in the same cycle");

    // Register zero is never written.
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (rf_waddr != '0))
        else $error("write to register zero");

    // Once halted, the program counter stays where it is.
    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> ($stable(pc_reg) && halt_reg))
        else $error("program counter moved after halt");

endmodule

>>> sim/eight_register_isa_executor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_register_isa_executor_top_tb
// Self-checking bench for the eight-register instruction executor. A
// scoreboard class keeps its own copy of the program counter, registers,
// word memory and halt flag. It predicts the result of every accepted
// request and checks each result as it leaves the block. Stimulus opens
// with a short hand-written program. It then builds code at the program
// counter, so that most steps execute valid random instructions, and ends
// with a halt.
// ----------------------------------------------------------------------------
module eight_register_isa_executor_top_tb;
    import eir_pkg::*;

    localparam int MEM_WORDS    = MEM_WORDS_DEFAULT;
    localparam int CODE_TOP     = 767;
    localparam int RANDOM_ITEMS = 1270;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic [XLEN-1:0]   pc;
        logic              halted;
        logic              wvalid;
        logic [RIDX_W-1:0] widx;
        logic [XLEN-1:0]   wval;
        fault_t            fault;
    } step_result_t;

    // What one instruction would do from the current state.
    typedef struct packed {
        op_t               op;
        logic [XLEN-1:0]   npc;
        logic              wr;
        logic [RIDX_W-1:0] widx;
        logic [XLEN-1:0]   wval;
        logic [XLEN-1:0]   ea;
        logic              ea_ok;
    } outcome_t;

    class executor_scoreboard;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] regs [RF_DEPTH];
        logic [XLEN-1:0] memory_words [MEM_WORDS];
        bit              written [MEM_WORDS];
        int              used_words;
        bit              halt_flag;
        step_result_t    expected_results [$];
        int              checked;
        int              errors;

        function new();
            pc = '0;
            foreach (regs[i]) regs[i] = '0;
            used_words = 0;
            halt_flag  = 1'b0;
            checked    = 0;
            errors     = 0;
        endfunction

        // Register zero always reads as zero.
        function logic [XLEN-1:0] reg_value(logic [RIDX_W-1:0] idx);
            return (idx == 0) ? '0 : regs[idx];
        endfunction

        // Decode and evaluate one instruction without changing any state.
        function outcome_t evaluate(logic [XLEN-1:0] ins);
            outcome_t          o;
            logic [RIDX_W-1:0] ra;
            logic [RIDX_W-1:0] rb;
            logic [XLEN-1:0]   a;
            logic [XLEN-1:0]   b;
            logic [XLEN-1:0]   off;
            ra      = ins[RA_LSB +: RIDX_W];
            rb      = ins[RB_LSB +: RIDX_W];
            a       = reg_value(ra);
            b       = reg_value(rb);
            off     = {{(XLEN-OFF_W){ins[OFF_W-1]}}, ins[OFF_W-1:0]};
            o       = '0;
            o.op    = op_t'(ins[OP_LSB +: OP_W]);
            o.npc   = pc + 1;
            o.ea    = a + off;
            o.ea_ok = !o.ea[XLEN-1] && o.ea < MEM_WORDS;
            case (o.op)
                OP_ADD:
                begin
                    o.wr   = 1'b1;
                    o.widx = ins[RD_LSB +: RIDX_W];
                    o.wval = a + b;
                end
                OP_NOR:
                begin
                    o.wr   = 1'b1;
                    o.widx = ins[RD_LSB +: RIDX_W];
                    o.wval = ~(a | b);
                end
                OP_LW:
                begin
                    if (o.ea_ok)
                    begin
                        o.wr   = 1'b1;
                        o.widx = rb;
                        o.wval = memory_words[o.ea];
                    end
                end
                OP_SW:
                begin
                    o.wval = b;
                end
                OP_BEQ:
                begin
                    if (a == b) o.npc = pc + 1 + off;
                end
                OP_JALR:
                begin
                    // The link value is taken before the jump target is read.
                    o.npc  = (ra == rb) ? pc + 1 : a;
                    o.wr   = 1'b1;
                    o.widx = rb;
                    o.wval = pc + 1;
                end
                default:
                begin
                end
            endcase
            return o;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(cmd_t cmd, logic [LADDR_W-1:0] addr, logic [XLEN-1:0] data);
            step_result_t r;
            outcome_t     o;
            r = '0;
            if (cmd == CMD_LOAD)
            begin
                if (addr < MEM_WORDS)
                begin
                    memory_words[addr] = data;
                    written[addr]      = 1'b1;
                    if (used_words <= addr) used_words = addr + 1;
                end
                else
                begin
                    r.fault = FAULT_ADDR;
                end
            end
            else if (!halt_flag)
            begin
                if (pc[XLEN-1] || pc >= used_words)
                begin
                    r.fault = FAULT_PC;
                end
                else
                begin
                    o = evaluate(memory_words[pc]);
                    if ((o.op == OP_LW || o.op == OP_SW) && !o.ea_ok) r.fault = FAULT_ADDR;
                    if (o.op == OP_SW && o.ea_ok)
                    begin
                        memory_words[o.ea] = o.wval;
                        written[o.ea]      = 1'b1;
                    end
                    if (o.op == OP_HALT) halt_flag = 1'b1;
                    if (o.wr && o.widx != 0)
                    begin
                        regs[o.widx] = o.wval;
                        r.wvalid     = 1'b1;
                        r.widx       = o.widx;
                        r.wval       = o.wval;
                    end
                    pc = o.npc;
                end
            end
            r.pc     = pc;
            r.halted = halt_flag;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS) $display("mismatch on result %0d: %s", checked, what);
            errors++;
        endtask

        // Compare one result from the block with the oldest prediction.
        task check_result(step_result_t got);
            step_result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got.pc !== want.pc)
                report_mismatch($sformatf("next_pc %h, expected %h", got.pc, want.pc));
            if (got.halted !== want.halted)
                report_mismatch($sformatf("halted %b, expected %b", got.halted, want.halted));
            if (got.wvalid !== want.wvalid)
                report_mismatch($sformatf("reg_write_valid %b, expected %b",
                                          got.wvalid, want.wvalid));
            if (got.widx !== want.widx)
                report_mismatch($sformatf("reg_write_index %0d, expected %0d",
                                          got.widx, want.widx));
            if (got.wval !== want.wval)
                report_mismatch($sformatf("reg_write_value %h, expected %h",
                                          got.wval, want.wval));
            if (got.fault !== want.fault)
                report_mismatch($sformatf("fault %0d, expected %0d", got.fault, want.fault));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic                     command      = CMD_LOAD;
    logic [LADDR_W-1:0]       load_address = '0;
    logic signed [XLEN-1:0]   load_data    = '0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic signed [XLEN-1:0]   next_pc;
    logic                     halted;
    logic                     reg_write_valid;
    logic [RIDX_W-1:0]        reg_write_index;
    logic signed [XLEN-1:0]   reg_write_value;
    logic [1:0]               fault;

    executor_scoreboard sb;
    bit                 steady = 1'b0;

    eight_register_isa_executor_top #(
        .MEM_WORDS       (MEM_WORDS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .load_address    (load_address),
        .load_data       (load_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_pc         (next_pc),
        .halted          (halted),
        .reg_write_valid (reg_write_valid),
        .reg_write_index (reg_write_index),
        .reg_write_value (reg_write_value),
        .fault           (fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build an instruction word; unused bits are left random.
    function automatic logic [XLEN-1:0] encode(op_t op, logic [RIDX_W-1:0] ra,
                                               logic [RIDX_W-1:0] rb, logic [OFF_W-1:0] low);
        logic [XLEN-1:0] w;
        w = $urandom();
        w[OP_LSB +: OP_W]   = op;
        w[RA_LSB +: RIDX_W] = ra;
        w[RB_LSB +: RIDX_W] = rb;
        if (op == OP_ADD || op == OP_NOR) w[RD_LSB +: RIDX_W] = low[RIDX_W-1:0];
        else w[OFF_W-1:0] = low;
        return w;
    endfunction

    // An instruction may run at the current pc if it does not halt, keeps the
    // pc inside the code area and loads only from words already written.
    function automatic bit runnable(logic [XLEN-1:0] ins);
        outcome_t o;
        o = sb.evaluate(ins);
        if (o.op == OP_HALT || o.npc[XLEN-1] || o.npc > CODE_TOP) return 1'b0;
        return !(o.op == OP_LW && o.ea_ok && !sb.written[o.ea]);
    endfunction

    // Random instruction with offsets aimed at useful targets part of the time.
    function automatic logic [XLEN-1:0] random_instruction();
        op_t               op;
        logic [RIDX_W-1:0] ra;
        logic [RIDX_W-1:0] rb;
        logic [OFF_W-1:0]  low;
        int                pick;
        int                reach;
        pick = $urandom_range(99);
        if (pick < 20) op = OP_ADD;
        else if (pick < 33) op = OP_NOR;
        else if (pick < 53) op = OP_LW;
        else if (pick < 68) op = OP_SW;
        else if (pick < 83) op = OP_BEQ;
        else if (pick < 95) op = OP_JALR;
        else op = OP_NOOP;
        ra  = RIDX_W'($urandom_range(7));
        rb  = RIDX_W'($urandom_range(7));
        low = OFF_W'($urandom());
        if (op == OP_BEQ && $urandom_range(1) == 1) rb = ra;
        case ($urandom_range(3))
            0:
            begin
                // Keep the full-range offset.
            end
            1:
            begin
                low = OFF_W'($urandom_range(16) - 8);
            end
            default:
            begin
                if (op == OP_BEQ)
                begin
                    reach = (sb.used_words + 8 < CODE_TOP) ? sb.used_words + 8 : CODE_TOP;
                    low   = OFF_W'($urandom_range(reach) - sb.pc - 1);
                end
                else
                begin
                    ra  = '0;
                    low = (op == OP_LW) ? OFF_W'($urandom_range(CODE_TOP))
                                        : OFF_W'($urandom_range(MEM_WORDS - 1));
                end
            end
        endcase
        return encode(op, ra, rb, low);
    endfunction

    function automatic logic [XLEN-1:0] fresh_instruction();
        logic [XLEN-1:0] w;
        repeat (20)
        begin
            w = random_instruction();
            if (runnable(w)) return w;
        end
        // A branch back to word zero is always safe to run.
        return encode(OP_BEQ, '0, '0, OFF_W'(-(sb.pc + 1)));
    endfunction

    // Present one request, hold it until accepted, then record it.
    task automatic send_request(cmd_t cmd, logic [LADDR_W-1:0] addr, logic [XLEN-1:0] data);
        while (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        load_address <= addr;
        load_data    <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(cmd, addr, data);
    endtask

    task automatic send_step();
        send_request(CMD_STEP, LADDR_W'($urandom_range(MEM_WORDS - 1)), $urandom());
    endtask

    // Pick the next request: mostly run or write code at the pc, with some
    // data loads and steps that fetch beyond the loaded words.
    task automatic random_request();
        logic [LADDR_W-1:0] where;
        logic [XLEN-1:0]    data;
        bit                 in_code;
        bit                 fetchable;
        int                 roll;
        in_code   = sb.pc < sb.used_words;
        fetchable = in_code && sb.written[sb.pc] && runnable(sb.memory_words[sb.pc]);
        roll      = $urandom_range(99);
        if (fetchable && roll < 65)
        begin
            send_step();
        end
        else if (!in_code && roll < 30)
        begin
            send_step();
        end
        else if (roll >= 85)
        begin
            where = ($urandom_range(7) == 0) ? LADDR_W'($urandom_range(CODE_TOP))
                                             : LADDR_W'($urandom_range(63));
            case ($urandom_range(5))
                0: data = 32'h7FFF_FFFF;
                1: data = 32'h8000_0000;
                2: data = '0;
                3: data = '1;
                4: data = $urandom_range(40);
                default: data = $urandom();
            endcase
            send_request(CMD_LOAD, where, data);
        end
        else
        begin
            send_request(CMD_LOAD, sb.pc[LADDR_W-1:0], fresh_instruction());
        end
    endtask

    // Stimulus: reset, a hand-written program, random code, then halt.
    initial
    begin
        logic [XLEN-1:0] boot_code [11];
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A step before anything is loaded fetches outside the used words.
        send_step();
        send_request(CMD_LOAD, 10'd20, 32'h7FFF_FFFF);
        send_request(CMD_LOAD, 10'd21, 32'h8000_0000);

        // Word 8 stays empty: the branch at word 7 must skip it.
        boot_code[0]  = encode(OP_LW, 3'd0, 3'd1, 16'd20);
        boot_code[1]  = encode(OP_LW, 3'd0, 3'd2, 16'd21);
        boot_code[2]  = encode(OP_ADD, 3'd1, 3'd2, 16'd3);
        boot_code[3]  = encode(OP_ADD, 3'd1, 3'd1, 16'd0);
        boot_code[4]  = encode(OP_NOR, 3'd1, 3'd2, 16'd4);
        boot_code[5]  = encode(OP_SW, 3'd0, 3'd3, 16'd22);
        boot_code[6]  = encode(OP_LW, 3'd3, 3'd5, 16'hFFFF);
        boot_code[7]  = encode(OP_BEQ, 3'd0, 3'd4, 16'd1);
        boot_code[8]  = encode(OP_BEQ, 3'd1, 3'd2, 16'h8000);
        boot_code[9]  = encode(OP_JALR, 3'd6, 3'd6, 16'd0);
        boot_code[10] = encode(OP_BEQ, 3'd0, 3'd0, 16'd20);
        for (int i = 0; i < 11; i++)
            send_request(CMD_LOAD, LADDR_W'((i < 8) ? i : i + 1), boot_code[i]);
        repeat (12) send_step();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 450 && n < 750);
            random_request();
        end
        steady = 1'b0;

        // Halt at the current pc; later steps and loads leave pc and registers alone.
        send_request(CMD_LOAD, sb.pc[LADDR_W-1:0],
                     encode(OP_HALT, RIDX_W'($urandom()), RIDX_W'($urandom()),
                            OFF_W'($urandom())));
        repeat (4) send_step();
        send_request(CMD_LOAD, 10'h3FF, $urandom());
        send_step();
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: check each accepted result and stall at random.
    initial
    begin
        step_result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = {next_pc, halted, reg_write_valid, reg_write_index,
                       reg_write_value, fault};
                sb.check_result(got);
            end
            out_stall <= !steady && $urandom_range(99) < 33;
        end
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
